/* rtl/core/pfra_pkg.sv */
// Shared types, codes and sizing constants for the page frame allocator.
`timescale 1ns / 1ps

package pfra_pkg;

	localparam int NUM_FRAMES     = 1024;
	localparam int FRAME_SHIFT    = 12;
	localparam int COUNT_BITS_DEF = 16;

	localparam int FRAME_W   = $clog2(NUM_FRAMES);
	localparam int LINK_W    = $clog2(NUM_FRAMES + 1);
	localparam int PHYS_W    = 22;
	localparam int CNT_OUT_W = 16;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_FRAMES);

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_ADD   = 2'd2,
		FN_DROP  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_UNDER  = 3'd2,
		ST_REFD   = 3'd3,
		ST_DOUBLE = 3'd4,
		ST_OVER   = 3'd5
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [FRAME_W-1:0] frame_index;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0]   result_frame;
		logic [PHYS_W-1:0]    phys_address;
		logic [CNT_OUT_W-1:0] count_after;
		logic                 frame_released;
		status_t              status;
	} rsp_t;

	// Frame memory port control
	typedef struct packed {
		logic               re;
		logic               we;
		logic [FRAME_W-1:0] addr;
	} ram_ctl_t;

endpackage

/* rtl/core/pfra_frame_ram.sv */
// Per-frame memory: free-list link, free flag and reference count.
`timescale 1ns / 1ps

module pfra_frame_ram #(
	parameter int DATA_W = pfra_pkg::LINK_W + 1 + pfra_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  pfra_pkg::ram_ctl_t ctl,
	input  logic [DATA_W-1:0]  wdata,
	output logic [DATA_W-1:0]  rdata
);
	import pfra_pkg::*;

	logic [DATA_W-1:0] mem [NUM_FRAMES];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.addr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[ctl.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/pfra_ctrl.sv */
// Sequencer: clearing pass, read-modify-write of frame entries, result register.
`timescale 1ns / 1ps

module pfra_ctrl #(
	parameter int COUNT_BITS = pfra_pkg::COUNT_BITS_DEF,
	parameter int DATA_W     = pfra_pkg::LINK_W + 1 + COUNT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pfra_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pfra_pkg::rsp_t     rsp,
	output pfra_pkg::ram_ctl_t ram_ctl,
	output logic [DATA_W-1:0]  ram_wdata,
	input  logic [DATA_W-1:0]  ram_rdata
);
	import pfra_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t              state_q;
	logic [FRAME_W-1:0]  clr_q;
	logic [LINK_W-1:0]   head_q;
	func_t               func_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                out_valid_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                load;
	logic [FRAME_W-1:0]  rd_addr;
	logic [LINK_W-1:0]   rd_link;
	logic                rd_free;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic [LINK_W-1:0]   head_d;
	rsp_t                rsp_d;

	assign accept  = (state_q == S_IDLE) && req_valid;
	assign load    = (state_q == S_EXEC) && (!out_valid_q || !rsp_stall);
	assign rd_addr = (req.func == FN_ALLOC) ? head_q[FRAME_W-1:0] : req.frame_index;

	assign rd_link = ram_rdata[DATA_W-1 -: LINK_W];
	assign rd_free = ram_rdata[COUNT_BITS];
	assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
	assign cnt_inc = rd_cnt + COUNT_BITS'(1);
	assign cnt_dec = rd_cnt - COUNT_BITS'(1);

	// memory control for clearing and idle reads, decision and write-back in execute
	always_comb begin
		ram_ctl        = '0;
		ram_wdata      = '0;
		head_d         = head_q;
		rsp_d          = '0;
		rsp_d.status   = ST_OK;
		rsp_d.result_frame   = frame_q;
		rsp_d.phys_address   = PHYS_W'(frame_q) << FRAME_SHIFT;
		rsp_d.count_after    = CNT_OUT_W'(rd_cnt);
		rsp_d.frame_released = 1'b0;

		case (state_q)
			S_CLEAR: begin
				ram_ctl.we   = 1'b1;
				ram_ctl.addr = clr_q;
				ram_wdata    = {LINK_W'(clr_q) + LINK_W'(1), 1'b1, COUNT_BITS'(0)};
			end
			S_IDLE: begin
				ram_ctl.re   = accept;
				ram_ctl.addr = rd_addr;
			end
			S_EXEC: begin
				ram_ctl.addr = frame_q;
				case (func_q)
					FN_ALLOC: begin
						if (head_q == NULL_LINK) begin
							rsp_d.status       = ST_EMPTY;
							rsp_d.result_frame = '0;
							rsp_d.phys_address = '0;
							rsp_d.count_after  = '0;
						end else begin
							ram_ctl.we        = load;
							ram_wdata         = {NULL_LINK, 1'b0, COUNT_BITS'(0)};
							head_d            = rd_link;
							rsp_d.count_after = '0;
						end
					end
					FN_FREE: begin
						if (rd_free) begin
							rsp_d.status = ST_DOUBLE;
						end else if (rd_cnt != '0) begin
							rsp_d.status = ST_REFD;
						end else begin
							ram_ctl.we           = load;
							ram_wdata            = {head_q, 1'b1, COUNT_BITS'(0)};
							head_d               = LINK_W'(frame_q);
							rsp_d.frame_released = 1'b1;
						end
					end
					FN_ADD: begin
						if (rd_cnt == '1) begin
							rsp_d.status = ST_OVER;
						end else begin
							ram_ctl.we        = load;
							ram_wdata         = {rd_link, rd_free, cnt_inc};
							rsp_d.count_after = CNT_OUT_W'(cnt_inc);
						end
					end
					default: begin
						if (rd_cnt == '0) begin
							rsp_d.status = ST_UNDER;
						end else begin
							ram_ctl.we        = load;
							rsp_d.count_after = CNT_OUT_W'(cnt_dec);
							if (cnt_dec == '0 && !rd_free) begin
								ram_wdata            = {head_q, 1'b1, COUNT_BITS'(0)};
								head_d               = LINK_W'(frame_q);
								rsp_d.frame_released = 1'b1;
							end else begin
								ram_wdata = {rd_link, rd_free, cnt_dec};
							end
						end
					end
				endcase
			end
			default: begin
				ram_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			func_q      <= FN_ALLOC;
			frame_q     <= '0;
			out_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// a new result in the same cycle keeps the register full
			if (out_valid_q && !rsp_stall && !load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + FRAME_W'(1);
					if (clr_q == FRAME_W'(NUM_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						func_q  <= req.func;
						frame_q <= rd_addr;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (load) begin
						rsp_q       <= rsp_d;
						head_q      <= head_d;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_ctl.we)
		else $error("frame memory written while idle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_EXEC))
		else $error("accepted request not executed next cycle");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NULL_LINK)
		else $error("free list head out of range");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EXEC))
		else $error("result raised outside execute");

	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_q.frame_released) |-> (rsp_q.status == ST_OK))
		else $error("release flagged on rejected request");

endmodule

/* rtl/core/page_frame_refcount_allocator_top.sv */
// Top level of the page frame allocator with per-frame reference counts.
`timescale 1ns / 1ps

// Channel   Valid      Stall      Payload   Moves
// request   req_valid  req_stall  req       func, frame_index
// result    rsp_valid  rsp_stall  rsp       frame, address, count, release, status
//
// A request reads its frame entry from the single frame memory while idle; the
// execute state then decides, writes back and loads the result register.
// A request is taken only while the sequencer is idle, so one is in flight.
// After reset a clearing pass over all 1024 frames rebuilds the ascending free list
// and zero counts; req_stall stays high during it.
// A held result stalls only the execute step; the next request may be taken
// while the previous result still waits on rsp_stall.
module page_frame_refcount_allocator_top #(
	parameter int COUNT_BITS = pfra_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pfra_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pfra_pkg::rsp_t rsp
);
	import pfra_pkg::*;

	// entry layout: link to next free frame, free flag, reference count
	localparam int DATA_W = LINK_W + 1 + COUNT_BITS;

	ram_ctl_t          ram_ctl;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	pfra_ctrl #(
		.COUNT_BITS (COUNT_BITS),
		.DATA_W     (DATA_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.ram_ctl   (ram_ctl),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	pfra_frame_ram #(
		.DATA_W (DATA_W)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

/* tb/sv/tb_page_frame_refcount_allocator_top.sv */
// Self-checking testbench for the page frame allocator: shadow list and counts, in-order check.
`timescale 1ns / 1ps

module tb_page_frame_refcount_allocator_top;
	import pfra_pkg::*;

	// Count width under test and its saturation value
	localparam int              CNT_BITS = COUNT_BITS_DEF;
	localparam longint unsigned CNT_MAX  = (64'd1 << CNT_BITS) - 64'd1;
	// End-of-list marker in the shadow free list
	localparam int              FL_NONE  = NUM_FRAMES;
	// Hard stop for the whole run, clearing pass and all tests included
	localparam longint          RUN_LIMIT_NS = 1_000_000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_valid;
	logic req_stall;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Shadow of the allocator state, advanced once per accepted request
	int              fl_head;
	int              fl_link       [NUM_FRAMES];
	longint unsigned frame_refs    [NUM_FRAMES];
	bit              frame_on_list [NUM_FRAMES];

	// Results owed by the block, oldest first
	rsp_t due_results [$];

	int error_count     = 0;
	int send_idle_pct   = 0;   // chance per cycle that the sender holds back
	int rsp_stall_pct   = 0;   // chance per cycle that the receiver stalls
	int hold_off_cycles = 0;   // long receiver hold-off, counted down below

	page_frame_refcount_allocator_top #(
		.COUNT_BITS(CNT_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------

	function automatic void reset_frame_table();
		for (int i = 0; i < NUM_FRAMES; i++) begin
			fl_link[i]       = i + 1;
			frame_refs[i]    = 0;
			frame_on_list[i] = 1'b1;
		end
		fl_link[NUM_FRAMES-1] = FL_NONE;
		fl_head = 0;
	endfunction

	function automatic rsp_t frame_result(int f, longint unsigned cnt, bit rel, status_t st);
		rsp_t r;
		r.result_frame   = FRAME_W'(f);
		r.phys_address   = PHYS_W'(longint'(f) << FRAME_SHIFT);
		r.count_after    = CNT_OUT_W'(cnt);
		r.frame_released = rel;
		r.status         = st;
		return r;
	endfunction

	function automatic void push_free(int f);
		fl_link[f]       = fl_head;
		fl_head          = f;
		frame_on_list[f] = 1'b1;
	endfunction

	// Applies one request to the shadow state and returns the result it owes
	function automatic rsp_t predict_request(func_t fn, logic [FRAME_W-1:0] idx);
		int f;
		int h;
		f = int'(idx) % NUM_FRAMES;
		case (fn)
		FN_ALLOC: begin
			h = fl_head;
			if (h == FL_NONE)
				return frame_result(0, 0, 1'b0, ST_EMPTY);
			fl_head          = fl_link[h];
			fl_link[h]       = FL_NONE;
			frame_on_list[h] = 1'b0;
			frame_refs[h]    = 0;
			return frame_result(h, 0, 1'b0, ST_OK);
		end
		FN_FREE: begin
			if (frame_on_list[f])
				return frame_result(f, frame_refs[f], 1'b0, ST_DOUBLE);
			if (frame_refs[f] != 0)
				return frame_result(f, frame_refs[f], 1'b0, ST_REFD);
			push_free(f);
			return frame_result(f, 0, 1'b1, ST_OK);
		end
		FN_ADD: begin
			if (frame_refs[f] >= CNT_MAX)
				return frame_result(f, frame_refs[f], 1'b0, ST_OVER);
			frame_refs[f]++;
			return frame_result(f, frame_refs[f], 1'b0, ST_OK);
		end
		default: begin
			if (frame_refs[f] == 0)
				return frame_result(f, 0, 1'b0, ST_UNDER);
			frame_refs[f]--;
			// a frame already on the list is not pushed a second time
			if (frame_refs[f] == 0 && !frame_on_list[f]) begin
				push_free(f);
				return frame_result(f, 0, 1'b1, ST_OK);
			end
			return frame_result(f, frame_refs[f], 1'b0, ST_OK);
		end
		endcase
	endfunction

	// Some frame currently off the list (any frame if none is), so that requests hit live frames
	function automatic logic [FRAME_W-1:0] pick_held_frame();
		int start;
		start = $urandom_range(NUM_FRAMES - 1);
		for (int n = 0; n < NUM_FRAMES; n++)
			if (!frame_on_list[(start + n) % NUM_FRAMES])
				return FRAME_W'((start + n) % NUM_FRAMES);
		return FRAME_W'(start);
	endfunction

	// ------------------------------------------------------------------
	// Result side: receiver stall and checking
	// ------------------------------------------------------------------

	// Random stall, or a long hold-off when a test asks for one
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			rsp_stall       <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	function automatic void check_field(string field, logic [31:0] expv, logic [31:0] gotv);
		if (gotv !== expv) begin
			$error("%s: expected %0d, got %0d", field, expv, gotv);
			error_count++;
		end
	endfunction

	// Each result transfer is matched against the oldest owed result
	always @(posedge clk) begin
		rsp_t owed;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (due_results.size() == 0) begin
				$error("unexpected result transfer: frame %0d, status %0d",
					rsp.result_frame, rsp.status);
				error_count++;
			end else begin
				owed = due_results.pop_front();
				check_field("result_frame", owed.result_frame, rsp.result_frame);
				check_field("phys_address", owed.phys_address, rsp.phys_address);
				check_field("count_after", owed.count_after, rsp.count_after);
				check_field("frame_released", owed.frame_released, rsp.frame_released);
				check_field("status", owed.status, rsp.status);
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Valid is left high after the transfer; the next send or drain sets it
	// in the same step, so it is never lowered and raised within one step.
	task automatic send_req(input func_t fn, input logic [FRAME_W-1:0] idx,
			output rsp_t predicted);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{func: fn, frame_index: idx};
		do @(posedge clk); while (req_stall !== 1'b0);
		predicted = predict_request(fn, idx);
		due_results.push_back(predicted);
	endtask

	// Sender pauses until every owed result has arrived
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic set_idling(int send_pct, int stall_pct);
		send_idle_pct = send_pct;
		rsp_stall_pct <= stall_pct;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every operation and the list/count corner cases from the reset state
	task automatic test_basic_ops();
		rsp_t pred;
		set_idling(0, 0);
		send_req(FN_ALLOC, '1, pred);          // frame 0, index ignored
		send_req(FN_ALLOC, '0, pred);          // frame 1
		send_req(FN_FREE, 10'd0, pred);        // unreferenced: back on the list
		send_req(FN_FREE, 10'd0, pred);        // double free
		send_req(FN_FREE, 10'd1023, pred);     // never allocated
		send_req(FN_ADD, 10'd1, pred);
		send_req(FN_FREE, 10'd1, pred);        // still referenced
		send_req(FN_DROP, 10'd1, pred);        // hits zero, released
		send_req(FN_DROP, 10'd1, pred);        // underflow
		send_req(FN_ADD, 10'd5, pred);         // count on a free frame
		send_req(FN_DROP, 10'd5, pred);        // back to zero, not pushed twice
		send_req(FN_ADD, 10'd1023, pred);
		send_req(FN_DROP, 10'd1023, pred);
		send_req(FN_ALLOC, 10'd1023, pred);    // LIFO: 1, then 0, then 2
		send_req(FN_ALLOC, 10'd512, pred);
		send_req(FN_ALLOC, 10'd341, pred);
		send_req(FN_ADD, 10'd3, pred);         // frame 3 is now the head
		send_req(FN_ADD, 10'd3, pred);
		send_req(FN_ALLOC, 10'd682, pred);     // count cleared on allocate
		send_req(FN_DROP, 10'd3, pred);        // underflow after the clear
		send_req(FN_FREE, 10'd3, pred);
		drain();
	endtask

	// Allocate a batch, then free every held frame in random order
	task automatic test_alloc_free_batch();
		rsp_t pred;
		int held [$];
		int j;
		int k;
		int tmp;
		set_idling(17, 17);
		repeat (48) send_req(FN_ALLOC, FRAME_W'($urandom_range(NUM_FRAMES - 1)), pred);
		for (int i = 0; i < NUM_FRAMES; i++)
			if (!frame_on_list[i])
				held.push_back(i);
		for (j = held.size() - 1; j > 0; j--) begin
			k       = $urandom_range(j);
			tmp     = held[j];
			held[j] = held[k];
			held[k] = tmp;
		end
		foreach (held[n])
			send_req(FN_FREE, FRAME_W'(held[n]), pred);
		drain();
	endtask

	// Run one count up a long way, then back down to release
	task automatic test_count_run();
		rsp_t pred;
		logic [FRAME_W-1:0] f;
		set_idling(0, 0);
		send_req(FN_ALLOC, '0, pred);
		f = pred.result_frame;
		repeat (30) send_req(FN_ADD, f, pred);
		send_req(FN_FREE, f, pred);             // still referenced
		repeat (30) send_req(FN_DROP, f, pred); // last one releases
		drain();
	endtask

	// Receiver holds off long enough for the block to stall its input
	task automatic test_backpressure();
		rsp_t pred;
		set_idling(0, 0);
		hold_off_cycles <= 300;
		for (int n = 0; n < 12; n++)
			send_req((n % 2) ? FN_ADD : FN_ALLOC, pick_held_frame(), pred);
		drain();
	endtask

	// Mostly well-formed traffic on live frames, with some raw noise
	task automatic test_random_traffic(int n_items, int send_pct, int stall_pct);
		rsp_t pred;
		int roll;
		func_t fn;
		logic [FRAME_W-1:0] idx;
		set_idling(send_pct, stall_pct);
		repeat (n_items) begin
			roll = $urandom_range(99);
			if (roll < 15) begin
				fn  = func_t'($urandom_range(3));
				idx = FRAME_W'($urandom_range(NUM_FRAMES - 1));
			end else if (roll < 40) begin
				fn  = FN_ALLOC;
				idx = FRAME_W'($urandom_range(NUM_FRAMES - 1));
			end else begin
				idx  = pick_held_frame();
				roll = $urandom_range(99);
				fn   = (roll < 25) ? FN_FREE : (roll < 60) ? FN_ADD : FN_DROP;
			end
			send_req(fn, idx, pred);
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		reset_frame_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// req_stall covers the clearing pass, so the first send simply waits
		test_basic_ops();
		test_alloc_free_batch();
		test_count_run();
		test_backpressure();
		test_random_traffic(90, 0, 0);
		test_random_traffic(90, 70, 0);
		test_random_traffic(90, 0, 70);
		test_random_traffic(90, 17, 17);
		set_idling(0, 0);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_page_frame_refcount_allocator_top: done, clean");
		end else begin
			$display("tb_page_frame_refcount_allocator_top: done, errors");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("tb_page_frame_refcount_allocator_top: done, errors");
		$finish;
	end

endmodule
